// ===== rtl/ras_pkg.sv =====
// ----------------------------------------------------------------------------
// ras_pkg: shared types and constants of the Rossler step block
// Word format, request codes, shared-unit operations, operand codes and the
// control word that the sequencer hands to the datapath.
// ----------------------------------------------------------------------------
package ras_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 24;
    localparam int DT_BITS   = 25;
    localparam int REQ_BITS  = 3;
    localparam int CFG_BITS  = 3;

    localparam longint ONE_L = 64'sd1 <<< FRAC_BITS;
    localparam logic signed [WORD_BITS-1:0] ONE_Q  = WORD_BITS'(ONE_L);
    localparam logic signed [WORD_BITS-1:0] DEF_AB = WORD_BITS'((ONE_L * 2 + 5) / 10);
    localparam logic signed [WORD_BITS-1:0] DEF_C  = WORD_BITS'((ONE_L * 57 + 5) / 10);
    localparam logic [DT_BITS-1:0]          DEF_DT = DT_BITS'((ONE_L + 50) / 100);

    typedef enum logic [REQ_BITS-1:0] {
        REQ_STEP    = 3'd0,
        REQ_RESTORE = 3'd1,
        REQ_LOAD_X  = 3'd2,
        REQ_LOAD_Y  = 3'd3,
        REQ_LOAD_Z  = 3'd4
    } t_req;

    typedef enum logic [CFG_BITS-1:0] {
        CFG_COEF_A   = 3'd0,
        CFG_COEF_B   = 3'd1,
        CFG_COEF_C   = 3'd2,
        CFG_STEP     = 3'd3,
        CFG_START_X  = 3'd4,
        CFG_START_Y  = 3'd5,
        CFG_START_Z  = 3'd6,
        CFG_EMIT     = 3'd7
    } t_cfg;

    // Saturating add, saturating subtract, rounded product with FRAC_BITS
    // shift, and the same product with one more bit of shift (halving).
    typedef enum logic [1:0] {
        OP_ADD       = 2'd0,
        OP_SUB       = 2'd1,
        OP_MULQ      = 2'd2,
        OP_MULQ_HALF = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        SRC_ZERO = 4'd0,
        SRC_X    = 4'd1,
        SRC_Y    = 4'd2,
        SRC_Z    = 4'd3,
        SRC_A    = 4'd4,
        SRC_B    = 4'd5,
        SRC_C    = 4'd6,
        SRC_DT   = 4'd7,
        SRC_FX   = 4'd8,
        SRC_FY   = 4'd9,
        SRC_FZ   = 4'd10,
        SRC_PX   = 4'd11,
        SRC_PY   = 4'd12,
        SRC_PZ   = 4'd13,
        SRC_T0   = 4'd14,
        SRC_T1   = 4'd15
    } t_src;

    typedef struct packed {
        t_op  op;
        t_src src_a;
        t_src src_b;
        t_src dst;
        logic wr;
    } t_ctrl;

endpackage

// ===== rtl/ras_alu.sv =====
// ----------------------------------------------------------------------------
// ras_alu: shared arithmetic unit
// Saturating add and subtract are combinational; the fixed-point multiply
// registers the product, then rounds half away from zero and saturates.
// ----------------------------------------------------------------------------
module ras_alu (
    input  logic                                 i_clk,
    input  ras_pkg::t_op                         i_op,
    input  logic signed [ras_pkg::WORD_BITS-1:0] i_a,
    input  logic signed [ras_pkg::WORD_BITS-1:0] i_b,
    output logic signed [ras_pkg::WORD_BITS-1:0] o_y
);

    localparam int W = ras_pkg::WORD_BITS;
    localparam int P = 2 * W;
    localparam int F = ras_pkg::FRAC_BITS;

    localparam logic signed [P-1:0] SAT_HI = {{(P-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [P-1:0] SAT_LO = ~SAT_HI;
    localparam logic signed [P-1:0] RND    = P'(64'sd1 <<< (F - 1));
    localparam logic signed [P-1:0] RND_H  = P'(64'sd1 <<< F);
    localparam logic signed [W-1:0] W_MAX  = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] W_MIN  = {1'b1, {(W-1){1'b0}}};

    logic signed [P-1:0] r_prod;
    logic signed [P-1:0] rnd;
    logic signed [P-1:0] biased;
    logic signed [P-1:0] shifted;
    logic signed [W-1:0] q_sat;
    logic signed [W:0]   sum;
    logic signed [W-1:0] s_sat;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    // Rounding away from zero: a negative product takes one less bias and
    // the arithmetic shift then floors toward minus infinity.
    always_comb begin
        rnd = (i_op == ras_pkg::OP_MULQ_HALF) ? RND_H : RND;
        if (r_prod[P-1]) begin
            rnd = rnd - P'(1);
        end
        biased = r_prod + rnd;
        if (i_op == ras_pkg::OP_MULQ_HALF) begin
            shifted = biased >>> (F + 1);
        end else begin
            shifted = biased >>> F;
        end
        if (shifted > SAT_HI) begin
            q_sat = W_MAX;
        end else if (shifted < SAT_LO) begin
            q_sat = W_MIN;
        end else begin
            q_sat = shifted[W-1:0];
        end
    end

    always_comb begin
        if (i_op == ras_pkg::OP_SUB) begin
            sum = {i_a[W-1], i_a} - {i_b[W-1], i_b};
        end else begin
            sum = {i_a[W-1], i_a} + {i_b[W-1], i_b};
        end
        if (sum[W] != sum[W-1]) begin
            s_sat = sum[W] ? W_MIN : W_MAX;
        end else begin
            s_sat = sum[W-1:0];
        end
    end

    always_comb begin
        case (i_op)
            ras_pkg::OP_ADD,
            ras_pkg::OP_SUB:  o_y = s_sat;
            default:          o_y = q_sat;
        endcase
    end

endmodule

// ===== rtl/ras_seq.sv =====
// ----------------------------------------------------------------------------
// ras_seq: microcode sequencer for one Heun step
// Walks the fixed operation list that evaluates the derivative, the
// predictor, the derivative at the predicted point and the corrector.
// ----------------------------------------------------------------------------
module ras_seq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    output logic           o_busy,
    output ras_pkg::t_ctrl o_ctrl
);

    localparam int PC_BITS   = 5;
    localparam logic [PC_BITS-1:0] LAST_STEP = PC_BITS'(30);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_state;

    t_state             r_state, n_state;
    logic [PC_BITS-1:0] r_pc, n_pc;
    logic               r_phase, n_phase;
    ras_pkg::t_ctrl     rom;
    logic               is_mul;
    logic               wr;

    function automatic ras_pkg::t_ctrl mk(ras_pkg::t_op op, ras_pkg::t_src a,
                                          ras_pkg::t_src b, ras_pkg::t_src d);
        ras_pkg::t_ctrl c;
        c.op    = op;
        c.src_a = a;
        c.src_b = b;
        c.dst   = d;
        c.wr    = 1'b0;
        return c;
    endfunction

    always_comb begin
        case (r_pc)
            // Derivative at the current point into FX, FY, FZ.
            5'd0:  rom = mk(ras_pkg::OP_ADD,  ras_pkg::SRC_Y,    ras_pkg::SRC_Z,  ras_pkg::SRC_T0);
            5'd1:  rom = mk(ras_pkg::OP_SUB,  ras_pkg::SRC_ZERO, ras_pkg::SRC_T0, ras_pkg::SRC_FX);
            5'd2:  rom = mk(ras_pkg::OP_MULQ, ras_pkg::SRC_A,    ras_pkg::SRC_Y,  ras_pkg::SRC_T0);
            5'd3:  rom = mk(ras_pkg::OP_ADD,  ras_pkg::SRC_X,    ras_pkg::SRC_T0, ras_pkg::SRC_FY);
            5'd4:  rom = mk(ras_pkg::OP_MULQ, ras_pkg::SRC_X,    ras_pkg::SRC_Z,  ras_pkg::SRC_T0);
            5'd5:  rom = mk(ras_pkg::OP_ADD,  ras_pkg::SRC_B,    ras_pkg::SRC_T0, ras_pkg::SRC_T0);
            5'd6:  rom = mk(ras_pkg::OP_MULQ, ras_pkg::SRC_C,    ras_pkg::SRC_Z,  ras_pkg::SRC_T1);
            5'd7:  rom = mk(ras_pkg::OP_SUB,  ras_pkg::SRC_T0,   ras_pkg::SRC_T1, ras_pkg::SRC_FZ);
            // Predicted point.
            5'd8:  rom = mk(ras_pkg::OP_MULQ, ras_pkg::SRC_DT,   ras_pkg::SRC_FX, ras_pkg::SRC_T0);
            5'd9:  rom = mk(ras_pkg::OP_ADD,  ras_pkg::SRC_X,    ras_pkg::SRC_T0, ras_pkg::SRC_PX);
            5'd10: rom = mk(ras_pkg::OP_MULQ, ras_pkg::SRC_DT,   ras_pkg::SRC_FY, ras_pkg::SRC_T0);
            5'd11: rom = mk(ras_pkg::OP_ADD,  ras_pkg::SRC_Y,    ras_pkg::SRC_T0, ras_pkg::SRC_PY);
            5'd12: rom = mk(ras_pkg::OP_MULQ, ras_pkg::SRC_DT,   ras_pkg::SRC_FZ, ras_pkg::SRC_T0);
            5'd13: rom = mk(ras_pkg::OP_ADD,  ras_pkg::SRC_Z,    ras_pkg::SRC_T0, ras_pkg::SRC_PZ);
            // Derivative at the predicted point, summed into FX, FY, FZ.
            5'd14: rom = mk(ras_pkg::OP_ADD,  ras_pkg::SRC_PY,   ras_pkg::SRC_PZ, ras_pkg::SRC_T0);
            5'd15: rom = mk(ras_pkg::OP_SUB,  ras_pkg::SRC_ZERO, ras_pkg::SRC_T0, ras_pkg::SRC_T0);
            5'd16: rom = mk(ras_pkg::OP_ADD,  ras_pkg::SRC_FX,   ras_pkg::SRC_T0, ras_pkg::SRC_FX);
            5'd17: rom = mk(ras_pkg::OP_MULQ, ras_pkg::SRC_A,    ras_pkg::SRC_PY, ras_pkg::SRC_T0);
            5'd18: rom = mk(ras_pkg::OP_ADD,  ras_pkg::SRC_PX,   ras_pkg::SRC_T0, ras_pkg::SRC_T0);
            5'd19: rom = mk(ras_pkg::OP_ADD,  ras_pkg::SRC_FY,   ras_pkg::SRC_T0, ras_pkg::SRC_FY);
            5'd20: rom = mk(ras_pkg::OP_MULQ, ras_pkg::SRC_PX,   ras_pkg::SRC_PZ, ras_pkg::SRC_T0);
            5'd21: rom = mk(ras_pkg::OP_ADD,  ras_pkg::SRC_B,    ras_pkg::SRC_T0, ras_pkg::SRC_T0);
            5'd22: rom = mk(ras_pkg::OP_MULQ, ras_pkg::SRC_C,    ras_pkg::SRC_PZ, ras_pkg::SRC_T1);
            5'd23: rom = mk(ras_pkg::OP_SUB,  ras_pkg::SRC_T0,   ras_pkg::SRC_T1, ras_pkg::SRC_T0);
            5'd24: rom = mk(ras_pkg::OP_ADD,  ras_pkg::SRC_FZ,   ras_pkg::SRC_T0, ras_pkg::SRC_FZ);
            // Corrector: half the summed slopes times dt.
            5'd25: rom = mk(ras_pkg::OP_MULQ_HALF, ras_pkg::SRC_DT, ras_pkg::SRC_FX, ras_pkg::SRC_T0);
            5'd26: rom = mk(ras_pkg::OP_ADD,  ras_pkg::SRC_X,    ras_pkg::SRC_T0, ras_pkg::SRC_X);
            5'd27: rom = mk(ras_pkg::OP_MULQ_HALF, ras_pkg::SRC_DT, ras_pkg::SRC_FY, ras_pkg::SRC_T0);
            5'd28: rom = mk(ras_pkg::OP_ADD,  ras_pkg::SRC_Y,    ras_pkg::SRC_T0, ras_pkg::SRC_Y);
            5'd29: rom = mk(ras_pkg::OP_MULQ_HALF, ras_pkg::SRC_DT, ras_pkg::SRC_FZ, ras_pkg::SRC_T0);
            5'd30: rom = mk(ras_pkg::OP_ADD,  ras_pkg::SRC_Z,    ras_pkg::SRC_T0, ras_pkg::SRC_Z);
            default: rom = mk(ras_pkg::OP_ADD, ras_pkg::SRC_ZERO, ras_pkg::SRC_ZERO,
                              ras_pkg::SRC_ZERO);
        endcase
    end

    // A multiply fills the product register while r_phase is low and writes
    // back once r_phase is set.
    assign is_mul = (rom.op == ras_pkg::OP_MULQ) || (rom.op == ras_pkg::OP_MULQ_HALF);
    assign wr     = (r_state == ST_RUN) && (!is_mul || r_phase);

    always_comb begin
        o_ctrl    = rom;
        o_ctrl.wr = wr;
    end

    assign o_busy = (r_state == ST_RUN);

    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        n_phase = r_phase;
        case (r_state)
            ST_IDLE: begin
                n_pc    = '0;
                n_phase = 1'b0;
                if (i_start) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (wr) begin
                    n_phase = 1'b0;
                    n_pc    = r_pc + PC_BITS'(1);
                    if (r_pc == LAST_STEP) begin
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_phase = 1'b1;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pc    <= '0;
            r_phase <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_phase <= n_phase;
        end
    end

endmodule

// ===== rtl/rossler_attractor_step.sv =====
// ----------------------------------------------------------------------------
// rossler_attractor_step: Rossler attractor noise source, Heun integration
// Holds a point of x'=-(y+z), y'=x+a*y, z'=b+x*z-c*z in signed Q8.24 and
// advances it one predictor-corrector step per step request, and per load request when emit on load is set.
// ----------------------------------------------------------------------------
// A step request is accepted and emits the point as it stood; the advance
// then runs 31 operations on one shared add/multiply unit, 19 saturating
// adds and 12 multiplies, and the input stays not ready until it is done.
// A load request with emit on load set starts the advance too; restore and
// load requests without emit do not. A new request is taken only when the
// output beat is free or being taken in the same cycle.
// Every sum and product saturates to the Q8.24 range; products round half
// away from zero. Configuration writes are taken in any cycle.
module rossler_attractor_step (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,  // [31:0] load_value
    input  logic [2:0]  i_s_axis_tuser,  // [2:0] req_type
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [95:0] o_m_axis_tdata   // [31:0] out_x, [63:32] out_y, [95:64] out_z
);

    localparam int W = ras_pkg::WORD_BITS;

    logic signed [W-1:0] r_coef_a, r_coef_b, r_coef_c;
    logic [ras_pkg::DT_BITS-1:0] r_dt;
    logic signed [W-1:0] r_start_x, r_start_y, r_start_z;
    logic                r_emit_on_load;
    logic signed [W-1:0] r_pos_x, r_pos_y, r_pos_z;
    logic signed [W-1:0] r_fx, r_fy, r_fz, r_px, r_py, r_pz, r_t0, r_t1;
    logic signed [W-1:0] r_out_x, r_out_y, r_out_z;
    logic                r_out_valid, n_out_valid;

    ras_pkg::t_ctrl      ctrl;
    logic                busy;
    logic                in_acc;
    logic                emit;
    ras_pkg::t_req       req;
    logic signed [W-1:0] load_v;
    logic signed [W-1:0] opa, opb, alu_y;
    logic signed [W-1:0] new_x, new_y, new_z;

    function automatic logic signed [W-1:0] pick(
        ras_pkg::t_src s,
        logic signed [W-1:0] x, logic signed [W-1:0] y, logic signed [W-1:0] z,
        logic signed [W-1:0] a, logic signed [W-1:0] b, logic signed [W-1:0] c,
        logic signed [W-1:0] dt,
        logic signed [W-1:0] fx, logic signed [W-1:0] fy, logic signed [W-1:0] fz,
        logic signed [W-1:0] px, logic signed [W-1:0] py, logic signed [W-1:0] pz,
        logic signed [W-1:0] t0, logic signed [W-1:0] t1);
        logic signed [W-1:0] v;
        case (s)
            ras_pkg::SRC_X:  v = x;
            ras_pkg::SRC_Y:  v = y;
            ras_pkg::SRC_Z:  v = z;
            ras_pkg::SRC_A:  v = a;
            ras_pkg::SRC_B:  v = b;
            ras_pkg::SRC_C:  v = c;
            ras_pkg::SRC_DT: v = dt;
            ras_pkg::SRC_FX: v = fx;
            ras_pkg::SRC_FY: v = fy;
            ras_pkg::SRC_FZ: v = fz;
            ras_pkg::SRC_PX: v = px;
            ras_pkg::SRC_PY: v = py;
            ras_pkg::SRC_PZ: v = pz;
            ras_pkg::SRC_T0: v = t0;
            ras_pkg::SRC_T1: v = t1;
            default:         v = '0;
        endcase
        return v;
    endfunction

    assign req    = ras_pkg::t_req'(i_s_axis_tuser);
    assign load_v = i_s_axis_tdata;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = !busy && (!r_out_valid || i_m_axis_tready);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        case (req)
            ras_pkg::REQ_STEP:   emit = 1'b1;
            ras_pkg::REQ_LOAD_X,
            ras_pkg::REQ_LOAD_Y,
            ras_pkg::REQ_LOAD_Z: emit = r_emit_on_load;
            default:             emit = 1'b0;
        endcase
    end

    // The point as it stands after this request's restore or load.
    always_comb begin
        new_x = r_pos_x;
        new_y = r_pos_y;
        new_z = r_pos_z;
        case (req)
            ras_pkg::REQ_RESTORE: begin
                new_x = r_start_x;
                new_y = r_start_y;
                new_z = r_start_z;
            end
            ras_pkg::REQ_LOAD_X: new_x = load_v;
            ras_pkg::REQ_LOAD_Y: new_y = load_v;
            ras_pkg::REQ_LOAD_Z: new_z = load_v;
            default: ;
        endcase
    end

    ras_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_acc && emit),
        .o_busy  (busy),
        .o_ctrl  (ctrl)
    );

    always_comb begin
        opa = pick(ctrl.src_a, r_pos_x, r_pos_y, r_pos_z, r_coef_a, r_coef_b, r_coef_c,
                   W'(r_dt), r_fx, r_fy, r_fz, r_px, r_py, r_pz, r_t0, r_t1);
        opb = pick(ctrl.src_b, r_pos_x, r_pos_y, r_pos_z, r_coef_a, r_coef_b, r_coef_c,
                   W'(r_dt), r_fx, r_fy, r_fz, r_px, r_py, r_pz, r_t0, r_t1);
    end

    ras_alu u_alu (
        .i_clk (i_clk),
        .i_op  (ctrl.op),
        .i_a   (opa),
        .i_b   (opb),
        .o_y   (alu_y)
    );

    always_ff @(posedge i_clk) begin
        if (ctrl.wr) begin
            case (ctrl.dst)
                ras_pkg::SRC_FX: r_fx <= alu_y;
                ras_pkg::SRC_FY: r_fy <= alu_y;
                ras_pkg::SRC_FZ: r_fz <= alu_y;
                ras_pkg::SRC_PX: r_px <= alu_y;
                ras_pkg::SRC_PY: r_py <= alu_y;
                ras_pkg::SRC_PZ: r_pz <= alu_y;
                ras_pkg::SRC_T0: r_t0 <= alu_y;
                ras_pkg::SRC_T1: r_t1 <= alu_y;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x <= ras_pkg::ONE_Q;
            r_pos_y <= ras_pkg::ONE_Q;
            r_pos_z <= ras_pkg::ONE_Q;
        end else if (in_acc) begin
            r_pos_x <= new_x;
            r_pos_y <= new_y;
            r_pos_z <= new_z;
        end else if (ctrl.wr) begin
            case (ctrl.dst)
                ras_pkg::SRC_X: r_pos_x <= alu_y;
                ras_pkg::SRC_Y: r_pos_y <= alu_y;
                ras_pkg::SRC_Z: r_pos_z <= alu_y;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_a       <= ras_pkg::DEF_AB;
            r_coef_b       <= ras_pkg::DEF_AB;
            r_coef_c       <= ras_pkg::DEF_C;
            r_dt           <= ras_pkg::DEF_DT;
            r_start_x      <= ras_pkg::ONE_Q;
            r_start_y      <= ras_pkg::ONE_Q;
            r_start_z      <= ras_pkg::ONE_Q;
            r_emit_on_load <= 1'b0;
        end else if (i_cfg_valid) begin
            case (ras_pkg::t_cfg'(i_cfg_index))
                ras_pkg::CFG_COEF_A:  r_coef_a       <= i_cfg_data;
                ras_pkg::CFG_COEF_B:  r_coef_b       <= i_cfg_data;
                ras_pkg::CFG_COEF_C:  r_coef_c       <= i_cfg_data;
                ras_pkg::CFG_STEP:    r_dt           <= i_cfg_data[ras_pkg::DT_BITS-1:0];
                ras_pkg::CFG_START_X: r_start_x      <= i_cfg_data;
                ras_pkg::CFG_START_Y: r_start_y      <= i_cfg_data;
                ras_pkg::CFG_START_Z: r_start_z      <= i_cfg_data;
                ras_pkg::CFG_EMIT:    r_emit_on_load <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Output beat: loaded with the point before the advance starts.
    always_comb begin
        n_out_valid = r_out_valid && !i_m_axis_tready;
        if (in_acc && emit) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && emit) begin
            r_out_x <= new_x;
            r_out_y <= new_y;
            r_out_z <= new_z;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_z, r_out_y, r_out_x};

endmodule
